/* rtl/core/cubic_triangle_field_interpolator_assert.svh */
// ============================================================================
// Assertion macros for the cubic triangle field interpolator
// Clocked property checks on i_clk; they compile away under SYNTHESIS.
// ============================================================================
`ifndef CUBIC_TRIANGLE_FIELD_INTERPOLATOR_ASSERT_SVH
`define CUBIC_TRIANGLE_FIELD_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define CTFI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked in every cycle, reset included.
`define CTFI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CTFI_ASSERT(lbl, prop, msg)
`define CTFI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/ctfi_pkg.sv */
// ============================================================================
// ctfi_pkg
// Shared constants, shape coefficient table and control types of the
// cubic triangle field interpolator.
// ============================================================================
package ctfi_pkg;

    // Default widths.
    localparam int VALUE_BITS_DEF      = 24;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Ten nodes and ten cubic monomials.
    localparam int NODES = 10;
    localparam int MONOS = 10;

    // Monomial positions: 1, u, v, uv, u^2, v^2, u^2v, uv^2, u^3, v^3.
    localparam int IDX_C   = 0;
    localparam int IDX_U   = 1;
    localparam int IDX_V   = 2;
    localparam int IDX_UV  = 3;
    localparam int IDX_U2  = 4;
    localparam int IDX_V2  = 5;
    localparam int IDX_U2V = 6;
    localparam int IDX_UV2 = 7;
    localparam int IDX_U3  = 8;
    localparam int IDX_V3  = 9;

    // Cubic Lagrange shape coefficients in units of one half.
    // Row is the node, column is the monomial.
    localparam int SHAPE_HALF [NODES][MONOS] = '{
        '{  2, -11, -11,  36,  18,  18, -27, -27,  -9,  -9 },
        '{  0,   2,   0,   0,  -9,   0,   0,   0,   9,   0 },
        '{  0,   0,   2,   0,   0,  -9,   0,   0,   0,   9 },
        '{  0,  18,   0, -45, -45,   0,  54,  27,  27,   0 },
        '{  0,  -9,   0,   9,  36,   0, -27,   0, -27,   0 },
        '{  0,   0,   0,  -9,   0,   0,  27,   0,   0,   0 },
        '{  0,   0,   0,  -9,   0,   0,   0,  27,   0,   0 },
        '{  0,   0,  -9,   9,   0,  36,   0, -27,   0, -27 },
        '{  0,   0,  18, -45,   0, -45,  27,  54,   0,  27 },
        '{  0,   0,   0,  54,   0,   0, -54, -54,   0,   0 }
    };

    // Load enables of the five pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

/* rtl/core/ctfi_if.sv */
// ============================================================================
// ctfi_if
// Valid/ready channels of the interpolator: the node word in and the
// result word out.
// ============================================================================

// Input channel: ten nodal values and a local point.
interface ctfi_in_if #(
    parameter int VALUE_BITS      = 24,
    parameter int COORD_FRAC_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_BITS-1:0] node_value_0;
    logic signed [VALUE_BITS-1:0] node_value_1;
    logic signed [VALUE_BITS-1:0] node_value_2;
    logic signed [VALUE_BITS-1:0] node_value_3;
    logic signed [VALUE_BITS-1:0] node_value_4;
    logic signed [VALUE_BITS-1:0] node_value_5;
    logic signed [VALUE_BITS-1:0] node_value_6;
    logic signed [VALUE_BITS-1:0] node_value_7;
    logic signed [VALUE_BITS-1:0] node_value_8;
    logic signed [VALUE_BITS-1:0] node_value_9;
    logic [COORD_FRAC_BITS:0]     pos_u;
    logic [COORD_FRAC_BITS:0]     pos_v;

    modport source (
        output valid, node_value_0, node_value_1, node_value_2, node_value_3,
               node_value_4, node_value_5, node_value_6, node_value_7,
               node_value_8, node_value_9, pos_u, pos_v,
        input  ready
    );
    modport sink (
        input  valid, node_value_0, node_value_1, node_value_2, node_value_3,
               node_value_4, node_value_5, node_value_6, node_value_7,
               node_value_8, node_value_9, pos_u, pos_v,
        output ready
    );
endinterface

// Output channel: interpolated value and both slopes.
interface ctfi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field_value;
    logic signed [31:0] slope_u;
    logic signed [31:0] slope_v;

    modport source (
        output valid, field_value, slope_u, slope_v,
        input  ready
    );
    modport sink (
        input  valid, field_value, slope_u, slope_v,
        output ready
    );
endinterface

/* rtl/core/cubic_triangle_field_interpolator.sv */
// ============================================================================
// cubic_triangle_field_interpolator
// Ten-node cubic triangle: interpolated value and both partial slopes at a
// local point, as a five-stage pipeline.
// ============================================================================
// Use: each word on i_in carries the ten nodal values and a point (u,v);
// each word on o_out returns field_value, slope_u and slope_v, saturated to
// 32 bits. Both channels are valid/ready; a word moves when both are high.
// From acceptance to o_out.valid a word passes the monomial and weighting
// stages s1 and s2, the product stage s3, the partial-sum stage s4 and the
// rounding stage s5. One word is accepted every cycle while the receiver
// keeps ready high, so the throughput is one result per cycle.
// Words leave in the order they arrived; exactly one result per word.
// When the receiver stalls, the output word holds and empty stages behind
// it still fill; i_in.ready falls only once all five stages hold a word.
// Reset clears the stage valid bits only; the pipeline is empty afterwards.
// ============================================================================
`include "cubic_triangle_field_interpolator_assert.svh"

module cubic_triangle_field_interpolator
    import ctfi_pkg::*;
#(
    parameter int VALUE_BITS      = VALUE_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctfi_in_if.sink     i_in,
    ctfi_out_if.source  o_out
);

    localparam int STAGES = 5;
    localparam int ACC_W  = VALUE_BITS + 9;
    localparam int MONO_W = COORD_FRAC_BITS + 4;

    logic [STAGES-1:0]            r_vld;
    logic [STAGES-1:0]            w_adv;
    t_stage_en                    w_en;
    logic signed [VALUE_BITS-1:0] w_node [NODES];
    logic signed [ACC_W-1:0]      w_acc  [MONOS];
    logic [MONO_W-1:0]            w_mv   [MONOS];
    logic [MONO_W-1:0]            w_mu   [MONOS];
    logic [MONO_W-1:0]            w_md   [MONOS];

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || o_out.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        w_en.s1 = w_adv[0];
        w_en.s2 = w_adv[1];
        w_en.s3 = w_adv[2];
        w_en.s4 = w_adv[3];
        w_en.s5 = w_adv[4];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_adv[0];
    assign o_out.valid = r_vld[STAGES-1];

    assign w_node[0] = i_in.node_value_0;
    assign w_node[1] = i_in.node_value_1;
    assign w_node[2] = i_in.node_value_2;
    assign w_node[3] = i_in.node_value_3;
    assign w_node[4] = i_in.node_value_4;
    assign w_node[5] = i_in.node_value_5;
    assign w_node[6] = i_in.node_value_6;
    assign w_node[7] = i_in.node_value_7;
    assign w_node[8] = i_in.node_value_8;
    assign w_node[9] = i_in.node_value_9;

    // Monomials of the point.
    ctfi_basis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_basis (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_u   (i_in.pos_u),
        .i_v   (i_in.pos_v),
        .o_mv  (w_mv),
        .o_mu  (w_mu),
        .o_md  (w_md)
    );

    // Polynomial coefficients from the nodal values.
    ctfi_weight #(
        .VALUE_BITS (VALUE_BITS)
    ) u_weight (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_node (w_node),
        .o_acc  (w_acc)
    );

    // Products, sums and output register.
    ctfi_combine #(
        .VALUE_BITS      (VALUE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_combine (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_acc     (w_acc),
        .i_mv      (w_mv),
        .i_mu      (w_mu),
        .i_md      (w_md),
        .o_field   (o_out.field_value),
        .o_slope_u (o_out.slope_u),
        .o_slope_v (o_out.slope_v)
    );

    // Pipeline checks.
    `CTFI_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> r_vld == '0, "pipeline not empty after reset")
    `CTFI_ASSERT(a_fill, i_in.valid && i_in.ready |=> r_vld[0], "accepted word not in stage one")
    `CTFI_ASSERT(a_hold, r_vld[3] && !w_en.s5 |=> r_vld[3], "stalled word lost in stage four")
    `CTFI_ASSERT(a_drain, o_out.valid && o_out.ready && !r_vld[3] |=> !o_out.valid, "result word repeated")

endmodule

/* rtl/core/ctfi_basis.sv */
// ============================================================================
// ctfi_basis
// Builds the ten cubic monomials of (u,v) and their u and v derivatives
// over two pipeline stages.
// ============================================================================
module ctfi_basis
    import ctfi_pkg::*;
#(
    parameter int  COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    localparam int CB              = COORD_FRAC_BITS + 1,
    localparam int MONO_W          = COORD_FRAC_BITS + 4
) (
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  logic [CB-1:0]     i_u,
    input  logic [CB-1:0]     i_v,
    output logic [MONO_W-1:0] o_mv [MONOS],
    output logic [MONO_W-1:0] o_mu [MONOS],
    output logic [MONO_W-1:0] o_md [MONOS]
);

    localparam int F    = COORD_FRAC_BITS;
    localparam int P2_W = 2 * CB;      // u*v before rounding
    localparam int Q2_W = F + 2;       // rounded second-order term
    localparam int P3_W = 2 * F + 3;   // second-order term times u or v
    localparam logic [P2_W-1:0]   RND2     = P2_W'(1) << (F - 1);
    localparam logic [P3_W-1:0]   RND3     = P3_W'(1) << (F - 1);
    localparam logic [MONO_W-1:0] MONO_ONE = MONO_W'(1) << F;

    logic [P2_W-1:0]   w_p_uv, w_p_u2, w_p_v2;
    logic [P3_W-1:0]   w_p_u2v, w_p_uv2, w_p_u3, w_p_v3;
    logic [CB-1:0]     r_u, r_v;
    logic [Q2_W-1:0]   r_uv, r_u2, r_v2;
    logic [MONO_W-1:0] n_mv [MONOS];
    logic [MONO_W-1:0] n_mu [MONOS];
    logic [MONO_W-1:0] n_md [MONOS];
    logic [MONO_W-1:0] r_mv [MONOS];
    logic [MONO_W-1:0] r_mu [MONOS];
    logic [MONO_W-1:0] r_md [MONOS];

    // Stage one: rounded second-order products of the coordinates.
    assign w_p_uv = P2_W'(i_u) * P2_W'(i_v) + RND2;
    assign w_p_u2 = P2_W'(i_u) * P2_W'(i_u) + RND2;
    assign w_p_v2 = P2_W'(i_v) * P2_W'(i_v) + RND2;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_u  <= i_u;
            r_v  <= i_v;
            r_uv <= w_p_uv[P2_W-1:F];
            r_u2 <= w_p_u2[P2_W-1:F];
            r_v2 <= w_p_v2[P2_W-1:F];
        end
    end

    // Stage two: rounded third-order products.
    assign w_p_u2v = P3_W'(r_u2) * P3_W'(r_v) + RND3;
    assign w_p_uv2 = P3_W'(r_v2) * P3_W'(r_u) + RND3;
    assign w_p_u3  = P3_W'(r_u2) * P3_W'(r_u) + RND3;
    assign w_p_v3  = P3_W'(r_v2) * P3_W'(r_v) + RND3;

    // Value monomials and both derivative sets.
    always_comb begin
        n_mv[IDX_C]   = MONO_ONE;
        n_mv[IDX_U]   = MONO_W'(r_u);
        n_mv[IDX_V]   = MONO_W'(r_v);
        n_mv[IDX_UV]  = MONO_W'(r_uv);
        n_mv[IDX_U2]  = MONO_W'(r_u2);
        n_mv[IDX_V2]  = MONO_W'(r_v2);
        n_mv[IDX_U2V] = MONO_W'(w_p_u2v[P3_W-1:F]);
        n_mv[IDX_UV2] = MONO_W'(w_p_uv2[P3_W-1:F]);
        n_mv[IDX_U3]  = MONO_W'(w_p_u3[P3_W-1:F]);
        n_mv[IDX_V3]  = MONO_W'(w_p_v3[P3_W-1:F]);

        n_mu[IDX_C]   = '0;
        n_mu[IDX_U]   = MONO_ONE;
        n_mu[IDX_V]   = '0;
        n_mu[IDX_UV]  = MONO_W'(r_v);
        n_mu[IDX_U2]  = MONO_W'({r_u, 1'b0});
        n_mu[IDX_V2]  = '0;
        n_mu[IDX_U2V] = MONO_W'({r_uv, 1'b0});
        n_mu[IDX_UV2] = MONO_W'(r_v2);
        n_mu[IDX_U3]  = MONO_W'(r_u2) + MONO_W'({r_u2, 1'b0});
        n_mu[IDX_V3]  = '0;

        n_md[IDX_C]   = '0;
        n_md[IDX_U]   = '0;
        n_md[IDX_V]   = MONO_ONE;
        n_md[IDX_UV]  = MONO_W'(r_u);
        n_md[IDX_U2]  = '0;
        n_md[IDX_V2]  = MONO_W'({r_v, 1'b0});
        n_md[IDX_U2V] = MONO_W'(r_u2);
        n_md[IDX_UV2] = MONO_W'({r_uv, 1'b0});
        n_md[IDX_U3]  = '0;
        n_md[IDX_V3]  = MONO_W'(r_v2) + MONO_W'({r_v2, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_mv <= n_mv;
            r_mu <= n_mu;
            r_md <= n_md;
        end
    end

    assign o_mv = r_mv;
    assign o_mu = r_mu;
    assign o_md = r_md;

endmodule

/* rtl/core/ctfi_weight.sv */
// ============================================================================
// ctfi_weight
// Weights the ten nodal values by the shape coefficient table, giving one
// exact coefficient per monomial in units of one half.
// ============================================================================
module ctfi_weight
    import ctfi_pkg::*;
#(
    parameter int  VALUE_BITS = VALUE_BITS_DEF,
    localparam int ACC_W      = VALUE_BITS + 9
) (
    input  logic                         i_clk,
    input  t_stage_en                    i_en,
    input  logic signed [VALUE_BITS-1:0] i_node [NODES],
    output logic signed [ACC_W-1:0]      o_acc  [MONOS]
);

    logic signed [ACC_W-1:0] n_acc  [MONOS];
    logic signed [ACC_W-1:0] r_acc1 [MONOS];
    logic signed [ACC_W-1:0] r_acc2 [MONOS];

    // Constant-coefficient sums; most table entries are zero.
    always_comb begin
        for (int j = 0; j < MONOS; j++) begin
            n_acc[j] = '0;
            for (int i = 0; i < NODES; i++) begin
                n_acc[j] = n_acc[j] + ACC_W'(i_node[i]) * ACC_W'(SHAPE_HALF[i][j]);
            end
        end
    end

    // Stage one holds the sums, stage two keeps them level with the monomials.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_acc1 <= n_acc;
        end
        if (i_en.s2) begin
            r_acc2 <= r_acc1;
        end
    end

    assign o_acc = r_acc2;

endmodule

/* rtl/core/ctfi_combine.sv */
// ============================================================================
// ctfi_combine
// Multiplies coefficients by monomials, adds the products in two stages,
// then rounds, scales and saturates the three results.
// ============================================================================
module ctfi_combine
    import ctfi_pkg::*;
#(
    parameter int  VALUE_BITS      = VALUE_BITS_DEF,
    parameter int  COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    localparam int ACC_W           = VALUE_BITS + 9,
    localparam int MONO_W          = COORD_FRAC_BITS + 4
) (
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  logic signed [ACC_W-1:0] i_acc [MONOS],
    input  logic [MONO_W-1:0]       i_mv  [MONOS],
    input  logic [MONO_W-1:0]       i_mu  [MONOS],
    input  logic [MONO_W-1:0]       i_md  [MONOS],
    output logic signed [31:0]      o_field,
    output logic signed [31:0]      o_slope_u,
    output logic signed [31:0]      o_slope_v
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int OUTS   = 3;
    localparam int HALF   = MONOS / 2;
    localparam int PROD_W = ACC_W + MONO_W + 1;
    localparam int SUM_W  = PROD_W + 4;
    localparam int EXT_W  = (SUM_W > 33) ? SUM_W : 33;
    localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << F;
    localparam logic signed [EXT_W-1:0] SAT_MAX = {{(EXT_W - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_MIN = {{(EXT_W - 31){1'b1}}, {31{1'b0}}};

    logic [MONO_W-1:0]        w_mono [OUTS][MONOS];
    logic signed [PROD_W-1:0] r_prod [OUTS][MONOS];
    logic signed [SUM_W-1:0]  n_part [OUTS][2];
    logic signed [SUM_W-1:0]  r_part [OUTS][2];
    logic signed [SUM_W-1:0]  w_total [OUTS];
    logic signed [EXT_W-1:0]  w_scaled [OUTS];
    logic signed [31:0]       n_res [OUTS];
    logic signed [31:0]       r_res [OUTS];

    always_comb begin
        for (int j = 0; j < MONOS; j++) begin
            w_mono[0][j] = i_mv[j];
            w_mono[1][j] = i_mu[j];
            w_mono[2][j] = i_md[j];
        end
    end

    // Stage three: one product per result and monomial.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int k = 0; k < OUTS; k++) begin
                for (int j = 0; j < MONOS; j++) begin
                    r_prod[k][j] <= PROD_W'(i_acc[j]) *
                                    PROD_W'($signed({1'b0, w_mono[k][j]}));
                end
            end
        end
    end

    // Stage four: two partial sums of five products each.
    always_comb begin
        for (int k = 0; k < OUTS; k++) begin
            for (int h = 0; h < 2; h++) begin
                n_part[k][h] = '0;
                for (int j = 0; j < HALF; j++) begin
                    n_part[k][h] = n_part[k][h] + SUM_W'(r_prod[k][h * HALF + j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_part <= n_part;
        end
    end

    // Stage five: final add, round half up, drop the scale and saturate.
    always_comb begin
        for (int k = 0; k < OUTS; k++) begin
            w_total[k]  = r_part[k][0] + r_part[k][1] + RND;
            w_scaled[k] = EXT_W'(w_total[k] >>> (F + 1));
            if (w_scaled[k] > SAT_MAX) begin
                n_res[k] = SAT_MAX[31:0];
            end else if (w_scaled[k] < SAT_MIN) begin
                n_res[k] = SAT_MIN[31:0];
            end else begin
                n_res[k] = w_scaled[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_res <= n_res;
        end
    end

    assign o_field   = r_res[0];
    assign o_slope_u = r_res[1];
    assign o_slope_v = r_res[2];

endmodule

/* tb/cubic_triangle_field_interpolator_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// cubic_triangle_field_interpolator_tb
// Self-checking bench for the ten-node cubic triangle interpolator. Words
// are sent on the input channel with random gaps, and the receiver stalls
// at random. Every accepted word is run through a local fixed-point model
// of the cubic shape functions. Each result word is checked field by field
// against the oldest outstanding prediction.
// ============================================================================
module cubic_triangle_field_interpolator_tb
    import ctfi_pkg::*;
();

    localparam int  VB           = VALUE_BITS_DEF;
    localparam int  FB           = COORD_FRAC_BITS_DEF;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  HOLD_CYCLES  = 60;
    localparam longint UNIT      = longint'(1) << FB;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -64'sd2147483648;
    localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic [FB:0]   COORD_MAX = '1;

    // Lagrange weights in halves; row is the node, column the monomial
    // 1, u, v, uv, u^2, v^2, u^2v, uv^2, u^3, v^3.
    localparam int HALF_WEIGHT [10][10] = '{
        '{  2, -11, -11,  36,  18,  18, -27, -27,  -9,  -9 },
        '{  0,   2,   0,   0,  -9,   0,   0,   0,   9,   0 },
        '{  0,   0,   2,   0,   0,  -9,   0,   0,   0,   9 },
        '{  0,  18,   0, -45, -45,   0,  54,  27,  27,   0 },
        '{  0,  -9,   0,   9,  36,   0, -27,   0, -27,   0 },
        '{  0,   0,   0,  -9,   0,   0,  27,   0,   0,   0 },
        '{  0,   0,   0,  -9,   0,   0,   0,  27,   0,   0 },
        '{  0,   0,  -9,   9,   0,  36,   0, -27,   0, -27 },
        '{  0,   0,  18, -45,   0, -45,  27,  54,   0,  27 },
        '{  0,   0,   0,  54,   0,   0, -54, -54,   0,   0 }
    };

    // Node positions in Q16, used to place points on each node.
    localparam int NODE_U [10] = '{0, 65536, 0, 21845, 43691, 43691, 21845, 0, 0, 21845};
    localparam int NODE_V [10] = '{0, 0, 65536, 0, 0, 21845, 43691, 43691, 21845, 21845};

    // Node signs that line up with the cubic terms, to drive saturation.
    localparam logic [9:0] STEEP_SIGNS = 10'b0101101110;

    typedef struct {
        logic signed [VB-1:0] node [NODES];
        logic [FB:0]          pos_u;
        logic [FB:0]          pos_v;
    } t_node_word;

    typedef struct {
        logic signed [31:0] field_value;
        logic signed [31:0] slope_u;
        logic signed [31:0] slope_v;
    } t_field_result;

    logic i_clk;
    logic i_rst_n;

    ctfi_in_if #(.VALUE_BITS(VB), .COORD_FRAC_BITS(FB)) in_ch ();
    ctfi_out_if out_ch ();

    cubic_triangle_field_interpolator #(
        .VALUE_BITS      (VB),
        .COORD_FRAC_BITS (FB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_field_result pending_fields[$];
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  sender_pauses   = 1'b1;
    bit  receiver_pauses = 1'b1;
    int  hold_off_left   = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Rounded Q16 product of two non-negative operands.
    function automatic longint q_product(input longint a, input longint b);
        return (a * b + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    // Exact sum in halves of Q16, rounded half up to integer, then clipped.
    function automatic logic signed [31:0] round_and_clip(input longint total);
        longint q;
        q = (total + (longint'(1) << FB)) >>> (FB + 1);
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        return q[31:0];
    endfunction

    // Interpolated value and both slopes of one word.
    function automatic t_field_result interpolate_field(input t_node_word w);
        longint weight [MONOS];
        longint m_val [MONOS];
        longint m_du [MONOS];
        longint m_dv [MONOS];
        longint u, v, uv, u2, v2;
        longint sum_val, sum_du, sum_dv;
        t_field_result r;
        int i, j;
        u  = longint'(w.pos_u);
        v  = longint'(w.pos_v);
        uv = q_product(u, v);
        u2 = q_product(u, u);
        v2 = q_product(v, v);
        for (j = 0; j < MONOS; j++) begin
            weight[j] = 0;
            for (i = 0; i < NODES; i++)
                weight[j] += longint'(HALF_WEIGHT[i][j]) * longint'(w.node[i]);
        end
        m_val[IDX_C]   = UNIT;  m_du[IDX_C]   = 0;      m_dv[IDX_C]   = 0;
        m_val[IDX_U]   = u;     m_du[IDX_U]   = UNIT;   m_dv[IDX_U]   = 0;
        m_val[IDX_V]   = v;     m_du[IDX_V]   = 0;      m_dv[IDX_V]   = UNIT;
        m_val[IDX_UV]  = uv;    m_du[IDX_UV]  = v;      m_dv[IDX_UV]  = u;
        m_val[IDX_U2]  = u2;    m_du[IDX_U2]  = 2 * u;  m_dv[IDX_U2]  = 0;
        m_val[IDX_V2]  = v2;    m_du[IDX_V2]  = 0;      m_dv[IDX_V2]  = 2 * v;
        m_val[IDX_U2V] = q_product(u2, v);
        m_du[IDX_U2V]  = 2 * uv;
        m_dv[IDX_U2V]  = u2;
        m_val[IDX_UV2] = q_product(u, v2);
        m_du[IDX_UV2]  = v2;
        m_dv[IDX_UV2]  = 2 * uv;
        m_val[IDX_U3]  = q_product(u2, u);
        m_du[IDX_U3]   = 3 * u2;
        m_dv[IDX_U3]   = 0;
        m_val[IDX_V3]  = q_product(v2, v);
        m_du[IDX_V3]   = 0;
        m_dv[IDX_V3]   = 3 * v2;
        sum_val = 0;
        sum_du  = 0;
        sum_dv  = 0;
        for (j = 0; j < MONOS; j++) begin
            sum_val += weight[j] * m_val[j];
            sum_du  += weight[j] * m_du[j];
            sum_dv  += weight[j] * m_dv[j];
        end
        r.field_value = round_and_clip(sum_val);
        r.slope_u     = round_and_clip(sum_du);
        r.slope_v     = round_and_clip(sum_dv);
        return r;
    endfunction

    // A random word: mostly points inside the element, some on the corners
    // of the unit square, and some anywhere in the coordinate range.
    function automatic t_node_word random_word();
        t_node_word w;
        int i;
        for (i = 0; i < NODES; i++) begin
            case ($urandom_range(0, 3))
                0: w.node[i] = VB'(int'($urandom_range(0, 2000)) - 1000);
                1: w.node[i] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                default: w.node[i] = VB'($urandom);
            endcase
        end
        case ($urandom_range(0, 9))
            7: begin
                w.pos_u = $urandom_range(0, 1) ? (FB+1)'(UNIT) : '0;
                w.pos_v = $urandom_range(0, 1) ? (FB+1)'(UNIT) : '0;
            end
            8, 9: begin
                w.pos_u = (FB+1)'($urandom);
                w.pos_v = (FB+1)'($urandom);
            end
            default: begin
                w.pos_u = (FB+1)'($urandom_range(0, int'(UNIT)));
                w.pos_v = (FB+1)'($urandom_range(0, int'(UNIT) - int'(w.pos_u)));
            end
        endcase
        return w;
    endfunction

    // Offer one word, called and returning at a falling edge.
    task automatic send_word(input t_node_word w);
        int gap;
        gap = sender_pauses ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.node_value_0 <= w.node[0];
        in_ch.node_value_1 <= w.node[1];
        in_ch.node_value_2 <= w.node[2];
        in_ch.node_value_3 <= w.node[3];
        in_ch.node_value_4 <= w.node[4];
        in_ch.node_value_5 <= w.node[5];
        in_ch.node_value_6 <= w.node[6];
        in_ch.node_value_7 <= w.node[7];
        in_ch.node_value_8 <= w.node[8];
        in_ch.node_value_9 <= w.node[9];
        in_ch.pos_u        <= w.pos_u;
        in_ch.pos_v        <= w.pos_v;
        in_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_fields.push_back(interpolate_field(w));
        @(negedge i_clk);
    endtask

    // Each node in turn at its own position, then extremes and a tiny step.
    task automatic test_node_points();
        t_node_word w;
        int k, i;
        for (k = 0; k < NODES; k++) begin
            for (i = 0; i < NODES; i++)
                w.node[i] = (i == k) ? VAL_MAX : VB'(-i);
            w.pos_u = (FB+1)'(NODE_U[k]);
            w.pos_v = (FB+1)'(NODE_V[k]);
            send_word(w);
        end
        // All nodes equal: constant field, zero slopes.
        for (i = 0; i < NODES; i++)
            w.node[i] = VAL_MAX;
        w.pos_u = '0;
        w.pos_v = '0;
        send_word(w);
        for (i = 0; i < NODES; i++)
            w.node[i] = VAL_MIN;
        w.pos_u = COORD_MAX;
        w.pos_v = COORD_MAX;
        send_word(w);
        // Smallest non-zero step in both coordinates.
        for (i = 0; i < NODES; i++)
            w.node[i] = '1;
        w.pos_u = (FB+1)'(1);
        w.pos_v = (FB+1)'(1);
        send_word(w);
    endtask

    // Far extrapolation with steep node patterns, so that every output
    // clips at both ends.
    task automatic test_extrapolation();
        t_node_word w;
        int p, s, i;
        for (s = 0; s < 2; s++) begin
            for (p = 0; p < 4; p++) begin
                for (i = 0; i < NODES; i++)
                    w.node[i] = (STEEP_SIGNS[i] ^ s[0]) ? VAL_MAX : VAL_MIN;
                w.pos_u = (p == 1) ? '0 : COORD_MAX;
                w.pos_v = (p == 2) ? '0 : COORD_MAX;
                if (p == 3) begin
                    w.pos_u = (FB+1)'(UNIT);
                    w.pos_v = (FB+1)'(UNIT);
                end
                send_word(w);
            end
        end
    endtask

    // The receiver holds off while words keep coming, so the pipeline
    // fills and the input channel must stall.
    task automatic test_output_stall();
        int n;
        sender_pauses = 1'b0;
        hold_off_left = HOLD_CYCLES;
        for (n = 0; n < 30; n++)
            send_word(random_word());
        sender_pauses = 1'b1;
    endtask

    // One word per cycle with neither side pausing.
    task automatic test_back_to_back();
        int n;
        sender_pauses   = 1'b0;
        receiver_pauses = 1'b0;
        for (n = 0; n < 200; n++)
            send_word(random_word());
        sender_pauses   = 1'b1;
        receiver_pauses = 1'b1;
    endtask

    // Bulk of the run: random words with random pauses on both sides.
    task automatic test_random_points();
        int n;
        for (n = 0; n < 1450; n++)
            send_word(random_word());
    endtask

    // Receiver: a random stall after each word, and the long hold-off.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                stall_left = receiver_pauses ? $urandom_range(0, 7) : 0;
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_field_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_fields.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %0d %0d %0d",
                         $time, out_ch.field_value, out_ch.slope_u, out_ch.slope_v);
                mismatch_count++;
            end else begin
                want = pending_fields.pop_front();
                check_field("field_value", want.field_value, out_ch.field_value);
                check_field("slope_u", want.slope_u, out_ch.slope_u);
                check_field("slope_v", want.slope_v, out_ch.slope_v);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_fields.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sequence of tests.
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.node_value_0 = '0;
        in_ch.node_value_1 = '0;
        in_ch.node_value_2 = '0;
        in_ch.node_value_3 = '0;
        in_ch.node_value_4 = '0;
        in_ch.node_value_5 = '0;
        in_ch.node_value_6 = '0;
        in_ch.node_value_7 = '0;
        in_ch.node_value_8 = '0;
        in_ch.node_value_9 = '0;
        in_ch.pos_u        = '0;
        in_ch.pos_v        = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_node_points();
        test_extrapolation();
        test_output_stall();
        test_back_to_back();
        test_random_points();
        in_ch.valid <= 1'b0;

        // Let the pipeline drain, then watch for stray words.
        while (pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* cubic_triangle_field_interpolator.f */
+incdir+rtl/core
rtl/core/ctfi_pkg.sv
rtl/core/ctfi_if.sv
rtl/core/ctfi_basis.sv
rtl/core/ctfi_weight.sv
rtl/core/ctfi_combine.sv
rtl/core/cubic_triangle_field_interpolator.sv
tb/cubic_triangle_field_interpolator_tb.sv
